FILE: rtl/crae_pkg.sv
// ----------------------------------------------------------------------------
// crae_pkg: shared types and constants of the register/ALU execute core
// Operation codes and status flag bit positions.
// ----------------------------------------------------------------------------
`default_nettype none

package crae_pkg;

    localparam int unsigned ModeWidth = 6;
    localparam int unsigned DataWidth = 8;

    // Operation codes carried on the mode field
    typedef enum logic [ModeWidth-1:0] {
        OP_ADC   = 6'd0,  OP_SBC   = 6'd1,  OP_AND   = 6'd2,  OP_ORA   = 6'd3,
        OP_EOR   = 6'd4,  OP_BIT   = 6'd5,  OP_CMP   = 6'd6,  OP_CPX   = 6'd7,
        OP_CPY   = 6'd8,  OP_ASL_A = 6'd9,  OP_ASL_M = 6'd10, OP_LSR_A = 6'd11,
        OP_LSR_M = 6'd12, OP_ROL_A = 6'd13, OP_ROL_M = 6'd14, OP_ROR_A = 6'd15,
        OP_ROR_M = 6'd16, OP_INC_M = 6'd17, OP_DEC_M = 6'd18, OP_INX   = 6'd19,
        OP_INY   = 6'd20, OP_DEX   = 6'd21, OP_DEY   = 6'd22, OP_LDA   = 6'd23,
        OP_LDX   = 6'd24, OP_LDY   = 6'd25, OP_STA   = 6'd26, OP_STX   = 6'd27,
        OP_STY   = 6'd28, OP_TAX   = 6'd29, OP_TAY   = 6'd30, OP_TXA   = 6'd31,
        OP_TYA   = 6'd32, OP_TSX   = 6'd33, OP_TXS   = 6'd34, OP_CLC   = 6'd35,
        OP_SEC   = 6'd36, OP_CLI   = 6'd37, OP_SEI   = 6'd38, OP_CLD   = 6'd39,
        OP_SED   = 6'd40, OP_CLV   = 6'd41, OP_PHA   = 6'd42, OP_PHP   = 6'd43,
        OP_PLA   = 6'd44, OP_PLP   = 6'd45, OP_BCC   = 6'd46, OP_BCS   = 6'd47,
        OP_BEQ   = 6'd48, OP_BNE   = 6'd49, OP_BMI   = 6'd50, OP_BPL   = 6'd51,
        OP_BVC   = 6'd52, OP_BVS   = 6'd53
    } op_t;

    // Status flag bit positions
    localparam int unsigned FlagC = 0;
    localparam int unsigned FlagZ = 1;
    localparam int unsigned FlagI = 2;
    localparam int unsigned FlagD = 3;
    localparam int unsigned FlagB = 4;
    localparam int unsigned FlagU = 5;
    localparam int unsigned FlagV = 6;
    localparam int unsigned FlagN = 7;

    // Reset value of the stack pointer
    localparam logic [DataWidth-1:0] SpReset = 8'hFD;
    // Bits forced high on a status push, and kept on a status pull
    localparam logic [DataWidth-1:0] PushMask = 8'h30;
    localparam logic [DataWidth-1:0] PullMask = 8'hCF;

endpackage : crae_pkg

`default_nettype wire

FILE: rtl/cpu_register_alu_execute_core.sv
// ----------------------------------------------------------------------------
// cpu_register_alu_execute_core: 8-bit register file and ALU execute unit
//
// Usage: each word on the s_ channel is one operation (s_mode) with its
// already fetched operand byte (s_operand). The core holds A, X, Y, the
// stack pointer and the status flags and answers each word with exactly one
// word on the m_ channel: the store byte and its strobe, the branch decision
// and all register values after the operation.
// Pipeline: the input register, then the result register loaded by the
// single-pass ALU and flag logic.
// Throughput: one word per cycle while m_ready is high; the loop through
// the architectural registers closes at the result register update, so
// back-to-back dependent operations need no stall.
// Stall: when m_ready is low the result word holds; the operation waiting in
// the input register also holds, and s_ready drops only when both are full.
// Reset: aresetn low clears both stages, A, X, Y and status to zero and sets
// the stack pointer to 0xFD.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_register_alu_execute_core
    import crae_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // operation words
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [ModeWidth-1:0] s_mode,
    input  wire logic [DataWidth-1:0] s_operand,
    // result words
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [DataWidth-1:0]      m_store_data,
    output logic                      m_store_valid,
    output logic                      m_branch_taken,
    output logic [DataWidth-1:0]      m_acc_out,
    output logic [DataWidth-1:0]      m_x_out,
    output logic [DataWidth-1:0]      m_y_out,
    output logic [DataWidth-1:0]      m_status_out,
    output logic [DataWidth-1:0]      m_stack_out
);

    // Input stage
    logic                 in_valid_reg;
    logic [ModeWidth-1:0] mode_reg;
    logic [DataWidth-1:0] operand_reg;

    // Architectural state
    logic [DataWidth-1:0] acc_reg, acc_next;
    logic [DataWidth-1:0] x_reg, x_next;
    logic [DataWidth-1:0] y_reg, y_next;
    logic [DataWidth-1:0] st_reg, st_next;
    logic [DataWidth-1:0] sp_reg, sp_next;

    // Result stage
    logic                 out_valid_reg;
    logic [DataWidth-1:0] sdata_reg, sdata_next;
    logic                 svalid_reg, svalid_next;
    logic                 taken_reg, taken_next;

    logic                 exec;

    // Intermediate ALU values
    logic [DataWidth-1:0] addend;
    logic [DataWidth:0]   sum;
    logic [DataWidth-1:0] cmp_src;
    logic [DataWidth:0]   diff;
    logic [DataWidth-1:0] shift_src;
    logic [DataWidth-1:0] shift_res;
    logic                 shift_cout;
    logic [DataWidth-1:0] nz_val;
    logic                 nz_en;

    // Execute when an operation waits and the result register is empty or being taken
    assign exec    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || exec;

    // Adder, comparator and shifter shared by their operations
    always_comb begin
        addend    = (op_t'(mode_reg) == OP_SBC) ? ~operand_reg : operand_reg;
        sum       = {1'b0, acc_reg} + {1'b0, addend} + {{DataWidth{1'b0}}, st_reg[FlagC]};
        case (op_t'(mode_reg))
            OP_CPX:  cmp_src = x_reg;
            OP_CPY:  cmp_src = y_reg;
            default: cmp_src = acc_reg;
        endcase
        diff      = {1'b0, cmp_src} - {1'b0, operand_reg};
        // even codes from ASL M up act on the operand, odd ones on A
        shift_src = mode_reg[0] ? acc_reg : operand_reg;
        case (op_t'(mode_reg))
            OP_ASL_A, OP_ASL_M: begin
                shift_res  = {shift_src[DataWidth-2:0], 1'b0};
                shift_cout = shift_src[DataWidth-1];
            end
            OP_ROL_A, OP_ROL_M: begin
                shift_res  = {shift_src[DataWidth-2:0], st_reg[FlagC]};
                shift_cout = shift_src[DataWidth-1];
            end
            OP_ROR_A, OP_ROR_M: begin
                shift_res  = {st_reg[FlagC], shift_src[DataWidth-1:1]};
                shift_cout = shift_src[0];
            end
            default: begin
                shift_res  = {1'b0, shift_src[DataWidth-1:1]};
                shift_cout = shift_src[0];
            end
        endcase
    end

    // Decode and compute the next state and result word
    always_comb begin
        acc_next    = acc_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        st_next     = st_reg;
        sp_next     = sp_reg;
        sdata_next  = '0;
        svalid_next = 1'b0;
        taken_next  = 1'b0;
        nz_val      = '0;
        nz_en       = 1'b0;
        case (op_t'(mode_reg))
            OP_ADC, OP_SBC: begin
                acc_next       = sum[DataWidth-1:0];
                st_next[FlagC] = sum[DataWidth];
                st_next[FlagV] = ~(acc_reg[7] ^ addend[7]) & (acc_reg[7] ^ sum[7]);
                nz_val         = sum[DataWidth-1:0];
                nz_en          = 1'b1;
            end
            OP_AND: begin
                acc_next = acc_reg & operand_reg;
                nz_val   = acc_reg & operand_reg;
                nz_en    = 1'b1;
            end
            OP_ORA: begin
                acc_next = acc_reg | operand_reg;
                nz_val   = acc_reg | operand_reg;
                nz_en    = 1'b1;
            end
            OP_EOR: begin
                acc_next = acc_reg ^ operand_reg;
                nz_val   = acc_reg ^ operand_reg;
                nz_en    = 1'b1;
            end
            OP_BIT: begin
                st_next[FlagZ] = ((acc_reg & operand_reg) == '0);
                st_next[FlagN] = operand_reg[7];
                st_next[FlagV] = operand_reg[6];
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                st_next[FlagC] = !diff[DataWidth];
                nz_val         = diff[DataWidth-1:0];
                nz_en          = 1'b1;
            end
            OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
                acc_next       = shift_res;
                st_next[FlagC] = shift_cout;
                nz_val         = shift_res;
                nz_en          = 1'b1;
            end
            OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
                sdata_next     = shift_res;
                svalid_next    = 1'b1;
                st_next[FlagC] = shift_cout;
                nz_val         = shift_res;
                nz_en          = 1'b1;
            end
            OP_INC_M: begin
                sdata_next  = operand_reg + 8'd1;
                svalid_next = 1'b1;
                nz_val      = operand_reg + 8'd1;
                nz_en       = 1'b1;
            end
            OP_DEC_M: begin
                sdata_next  = operand_reg - 8'd1;
                svalid_next = 1'b1;
                nz_val      = operand_reg - 8'd1;
                nz_en       = 1'b1;
            end
            OP_INX: begin
                x_next = x_reg + 8'd1;
                nz_val = x_reg + 8'd1;
                nz_en  = 1'b1;
            end
            OP_INY: begin
                y_next = y_reg + 8'd1;
                nz_val = y_reg + 8'd1;
                nz_en  = 1'b1;
            end
            OP_DEX: begin
                x_next = x_reg - 8'd1;
                nz_val = x_reg - 8'd1;
                nz_en  = 1'b1;
            end
            OP_DEY: begin
                y_next = y_reg - 8'd1;
                nz_val = y_reg - 8'd1;
                nz_en  = 1'b1;
            end
            OP_LDA: begin
                acc_next = operand_reg;
                nz_val   = operand_reg;
                nz_en    = 1'b1;
            end
            OP_LDX: begin
                x_next = operand_reg;
                nz_val = operand_reg;
                nz_en  = 1'b1;
            end
            OP_LDY: begin
                y_next = operand_reg;
                nz_val = operand_reg;
                nz_en  = 1'b1;
            end
            OP_STA: begin
                sdata_next  = acc_reg;
                svalid_next = 1'b1;
            end
            OP_STX: begin
                sdata_next  = x_reg;
                svalid_next = 1'b1;
            end
            OP_STY: begin
                sdata_next  = y_reg;
                svalid_next = 1'b1;
            end
            OP_TAX: begin
                x_next = acc_reg;
                nz_val = acc_reg;
                nz_en  = 1'b1;
            end
            OP_TAY: begin
                y_next = acc_reg;
                nz_val = acc_reg;
                nz_en  = 1'b1;
            end
            OP_TXA: begin
                acc_next = x_reg;
                nz_val   = x_reg;
                nz_en    = 1'b1;
            end
            OP_TYA: begin
                acc_next = y_reg;
                nz_val   = y_reg;
                nz_en    = 1'b1;
            end
            OP_TSX: begin
                x_next = sp_reg;
                nz_val = sp_reg;
                nz_en  = 1'b1;
            end
            OP_TXS:  sp_next = x_reg;
            OP_CLC:  st_next[FlagC] = 1'b0;
            OP_SEC:  st_next[FlagC] = 1'b1;
            OP_CLI:  st_next[FlagI] = 1'b0;
            OP_SEI:  st_next[FlagI] = 1'b1;
            OP_CLD:  st_next[FlagD] = 1'b0;
            OP_SED:  st_next[FlagD] = 1'b1;
            OP_CLV:  st_next[FlagV] = 1'b0;
            OP_PHA: begin
                sdata_next  = acc_reg;
                svalid_next = 1'b1;
                sp_next     = sp_reg - 8'd1;
            end
            OP_PHP: begin
                sdata_next  = st_reg | PushMask;
                svalid_next = 1'b1;
                sp_next     = sp_reg - 8'd1;
            end
            OP_PLA: begin
                sp_next  = sp_reg + 8'd1;
                acc_next = operand_reg;
                nz_val   = operand_reg;
                nz_en    = 1'b1;
            end
            OP_PLP: begin
                sp_next = sp_reg + 8'd1;
                st_next = operand_reg & PullMask;
            end
            OP_BCC:  taken_next = !st_reg[FlagC];
            OP_BCS:  taken_next = st_reg[FlagC];
            OP_BEQ:  taken_next = st_reg[FlagZ];
            OP_BNE:  taken_next = !st_reg[FlagZ];
            OP_BMI:  taken_next = st_reg[FlagN];
            OP_BPL:  taken_next = !st_reg[FlagN];
            OP_BVC:  taken_next = !st_reg[FlagV];
            OP_BVS:  taken_next = st_reg[FlagV];
            default: ;
        endcase
        // common zero and negative flag update
        if (nz_en) begin
            st_next[FlagZ] = (nz_val == '0);
            st_next[FlagN] = nz_val[DataWidth-1];
        end
        // unused bit always reads low
        st_next[FlagU] = 1'b0;
    end

    // Hold control state and the architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            st_reg        <= '0;
            sp_reg        <= SpReset;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (exec) begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                x_reg         <= x_next;
                y_reg         <= y_next;
                st_reg        <= st_next;
                sp_reg        <= sp_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture input payload and result payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg    <= s_mode;
            operand_reg <= s_operand;
        end
        if (exec) begin
            sdata_reg  <= sdata_next;
            svalid_reg <= svalid_next;
            taken_reg  <= taken_next;
        end
    end

    // Drive the result word
    assign m_valid        = out_valid_reg;
    assign m_store_data   = sdata_reg;
    assign m_store_valid  = svalid_reg;
    assign m_branch_taken = taken_reg;
    assign m_acc_out      = acc_reg;
    assign m_x_out        = x_reg;
    assign m_y_out        = y_reg;
    assign m_status_out   = st_reg;
    assign m_stack_out    = sp_reg;

endmodule : cpu_register_alu_execute_core

`default_nettype wire

FILE: rtl/crae_checker.sv
// ----------------------------------------------------------------------------
// crae_checker: port-level checks of the execute core
// Watches the result channel and the reset behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module crae_checker
    import crae_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [DataWidth-1:0] m_store_data,
    input wire logic                 m_store_valid,
    input wire logic                 m_branch_taken,
    input wire logic [DataWidth-1:0] m_status_out,
    input wire logic [DataWidth-1:0] m_stack_out
);

    // Stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_store_data)
            && $stable(m_status_out) && $stable(m_stack_out))
        else $error("stalled result word changed");

    // Store byte is zero without a store strobe
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_store_valid |-> m_store_data == '0)
        else $error("store byte set without store strobe");

    // No word both stores and takes a branch
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_store_valid && m_branch_taken))
        else $error("store and branch in one word");

    // Unused status bit always reads low
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_status_out[FlagU])
        else $error("unused status bit set");

    // Reset empties the result stage and restores the stack pointer
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && m_stack_out == SpReset)
        else $error("reset state wrong");

endmodule : crae_checker

bind cpu_register_alu_execute_core crae_checker u_crae_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_store_data  (m_store_data),
    .m_store_valid (m_store_valid),
    .m_branch_taken(m_branch_taken),
    .m_status_out  (m_status_out),
    .m_stack_out   (m_stack_out)
);

`default_nettype wire
